// ----- sv/pixel_to_ground_projection_unit_assert.svh -----
// assertion macros shared by the projection unit and its divider
// no dependencies; the including module supplies clock and reset names
`ifndef PIXEL_TO_GROUND_PROJECTION_UNIT_ASSERT_SVH
`define PIXEL_TO_GROUND_PROJECTION_UNIT_ASSERT_SVH

// same-cycle implication
`define PGP_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PGP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/pgp_pkg.sv -----
// types and constants of the pixel to ground projection unit
// used by pgp_div and pixel_to_ground_projection_unit
package pgp_pkg;

   // image geometry
   localparam int IMAGE_ROWS = 1024;
   localparam int IMAGE_COLS = 1024;
   localparam logic signed [12:0] ROW_HALF = 13'(IMAGE_ROWS / 2);
   localparam logic signed [12:0] COL_HALF = 13'(IMAGE_COLS / 2);

   // pipeline shape
   localparam int FRONT_STAGES = 7;
   localparam int DIV_STAGES = 8;
   localparam int DIV_BITS_PER_STAGE = 4;

   // divider widths
   localparam int QUO_W = 32;
   localparam int NUM_W = 62;
   localparam int DEN_W = 34;
   localparam int REM_W = 34;

   // csr port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_PITCH_ROW     = 3'd0,
      REG_PITCH_COL     = 3'd1,
      REG_FOCAL_LENGTH  = 3'd2,
      REG_DEPTH_SCALE   = 3'd3,
      REG_SIN_TILT      = 3'd4,
      REG_COS_TILT      = 3'd5,
      REG_CAMERA_HEIGHT = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   typedef struct packed {
      logic [11:0] pixel_row;
      logic [11:0] pixel_col;
   } req_type;

   typedef struct packed {
      logic signed [31:0] ground_lateral;
      logic signed [31:0] ground_forward;
      status_type         status;
   } rsp_type;

   // sideband that rides along with the division
   typedef struct packed {
      logic [DEN_W-1:0] den;
      logic             sign_lat;
      logic             sign_fwd;
      logic             big_lat;
      logic             big_fwd;
      logic             miss;
      logic             sat;
   } div_ctl_type;

   typedef struct packed {
      logic [NUM_W-1:0] num_lat;
      logic [NUM_W-1:0] num_fwd;
      div_ctl_type      ctl;
   } div_in_type;

   typedef struct packed {
      logic [QUO_W-1:0] q_lat;
      logic [QUO_W-1:0] q_fwd;
      div_ctl_type      ctl;
   } div_out_type;

endpackage

// ----- sv/pgp_div.sv -----
// pipelined restoring divider, two lanes sharing one denominator
// depends on pgp_pkg and the assertion macro header
`include "pixel_to_ground_projection_unit_assert.svh"

module pgp_div
   import pgp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_stall,
   input  div_in_type  in_data,
   output logic        out_valid,
   input  logic        out_stall,
   output div_out_type out_data
);

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] nlo;
      logic [QUO_W-1:0] q;
   } lane_type;

   // DIV_BITS_PER_STAGE restoring steps, one quotient bit each
   function automatic lane_type div_step(input lane_type lane, input logic [DEN_W-1:0] den);
      lane_type       r;
      logic [REM_W:0] t;
      r = lane;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         t = {r.rem, r.nlo[QUO_W-1]};
         r.nlo = {r.nlo[QUO_W-2:0], 1'b0};
         if (t >= {1'b0, den}) begin
            r.rem = REM_W'(t - {1'b0, den});
            r.q = {r.q[QUO_W-2:0], 1'b1};
         end else begin
            r.rem = t[REM_W-1:0];
            r.q = {r.q[QUO_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   lane_type    lat_ff [DIV_STAGES];
   lane_type    fwd_ff [DIV_STAGES];
   div_ctl_type ctl_ff [DIV_STAGES];
   lane_type    lat_in [DIV_STAGES];
   lane_type    fwd_in [DIV_STAGES];
   div_ctl_type ctl_in [DIV_STAGES];
   lane_type    lat_src [DIV_STAGES];
   lane_type    fwd_src [DIV_STAGES];
   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] valid_in;
   logic [DIV_STAGES:0]   adv;

   // stage advance, from the output back
   always_comb begin
      adv[DIV_STAGES] = !out_stall;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_stall = !adv[0];

   // stage sources and step logic
   always_comb begin
      lat_src[0] = '{rem: REM_W'(in_data.num_lat[NUM_W-1:QUO_W]),
                     nlo: in_data.num_lat[QUO_W-1:0], q: '0};
      fwd_src[0] = '{rem: REM_W'(in_data.num_fwd[NUM_W-1:QUO_W]),
                     nlo: in_data.num_fwd[QUO_W-1:0], q: '0};
      ctl_in[0] = in_data.ctl;
      valid_in[0] = in_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
         lat_src[k] = lat_ff[k-1];
         fwd_src[k] = fwd_ff[k-1];
         ctl_in[k] = ctl_ff[k-1];
         valid_in[k] = valid_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         lat_in[k] = div_step(lat_src[k], ctl_in[k].den);
         fwd_in[k] = div_step(fwd_src[k], ctl_in[k].den);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (adv[k]) begin
            lat_ff[k] <= lat_in[k];
            fwd_ff[k] <= fwd_in[k];
            ctl_ff[k] <= ctl_in[k];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_data = '{q_lat: lat_ff[DIV_STAGES-1].q, q_fwd: fwd_ff[DIV_STAGES-1].q,
                       ctl: ctl_ff[DIV_STAGES-1]};

   `PGP_ASSERT_NOW(a_div_stall_full, clock, reset, in_stall, valid_ff[0], "divider stalls while first stage is empty")
   `PGP_ASSERT_NEXT(a_div_hold, clock, reset, out_valid && out_stall, out_valid, "stalled quotient dropped")
   `PGP_ASSERT_NOW(a_div_rem, clock, reset, out_valid && !out_data.ctl.miss && !out_data.ctl.big_lat, lat_ff[DIV_STAGES-1].rem < out_data.ctl.den, "remainder not below denominator")

endmodule

// ----- sv/pixel_to_ground_projection_unit.sv -----
// pipeline: 7 arithmetic stages, 8 divider stages of 4 quotient bits
// each and 1 output register between input transfer and result
// throughput: one pixel per clock unless rsp_stall holds the output; a
// stalled result holds only as far as the pipeline fills behind it
// reset: synchronous, clears all valid bits and loads register defaults
// depends on pgp_pkg, pgp_div and the assertion macro header
`include "pixel_to_ground_projection_unit_assert.svh"

module pixel_to_ground_projection_unit
   import pgp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef struct packed {
      logic signed [31:0] value;
      logic               flag;
   } sat_type;

   localparam logic signed [65:0] SAT_MAX = 66'sh7FFFFFFF;
   localparam logic signed [65:0] SAT_MIN = -66'sh80000000;

   function automatic sat_type sat32(input logic signed [65:0] v);
      sat_type r;
      if (v > SAT_MAX) begin
         r = '{value: 32'sh7FFFFFFF, flag: 1'b1};
      end else if (v < SAT_MIN) begin
         r = '{value: 32'sh80000000, flag: 1'b1};
      end else begin
         r = '{value: v[31:0], flag: 1'b0};
      end
      return r;
   endfunction

   // signed result from quotient magnitude
   function automatic sat_type apply_sign(input logic [QUO_W-1:0] q, input logic sign,
                                          input logic big);
      sat_type r;
      if (big) begin
         r = '{value: sign ? 32'sh80000000 : 32'sh7FFFFFFF, flag: 1'b1};
      end else if (!sign) begin
         if (q[QUO_W-1]) begin
            r = '{value: 32'sh7FFFFFFF, flag: 1'b1};
         end else begin
            r = '{value: q, flag: 1'b0};
         end
      end else begin
         if (q > 32'h80000000) begin
            r = '{value: 32'sh80000000, flag: 1'b1};
         end else begin
            r = '{value: -q, flag: 1'b0};
         end
      end
      return r;
   endfunction

   // configuration registers
   logic [30:0]        pitch_row_ff;
   logic [30:0]        pitch_col_ff;
   logic [30:0]        focal_length_ff;
   logic [30:0]        depth_scale_ff;
   logic signed [17:0] sin_tilt_ff;
   logic signed [17:0] cos_tilt_ff;
   logic [30:0]        camera_height_ff;
   logic               csr_write;
   reg_index_type      csr_index;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_row_ff <= '0;
         pitch_col_ff <= '0;
         focal_length_ff <= '0;
         depth_scale_ff <= 31'd65536;
         sin_tilt_ff <= '0;
         cos_tilt_ff <= 18'sd65536;
         camera_height_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_PITCH_ROW: pitch_row_ff <= csr_pwdata[30:0];
            REG_PITCH_COL: pitch_col_ff <= csr_pwdata[30:0];
            REG_FOCAL_LENGTH: focal_length_ff <= csr_pwdata[30:0];
            REG_DEPTH_SCALE: depth_scale_ff <= csr_pwdata[30:0];
            REG_SIN_TILT: sin_tilt_ff <= csr_pwdata[17:0];
            REG_COS_TILT: cos_tilt_ff <= csr_pwdata[17:0];
            REG_CAMERA_HEIGHT: camera_height_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         REG_PITCH_ROW: csr_prdata = {1'b0, pitch_row_ff};
         REG_PITCH_COL: csr_prdata = {1'b0, pitch_col_ff};
         REG_FOCAL_LENGTH: csr_prdata = {1'b0, focal_length_ff};
         REG_DEPTH_SCALE: csr_prdata = {1'b0, depth_scale_ff};
         REG_SIN_TILT: csr_prdata = 32'(sin_tilt_ff);
         REG_COS_TILT: csr_prdata = 32'(cos_tilt_ff);
         REG_CAMERA_HEIGHT: csr_prdata = {1'b0, camera_height_ff};
         default: csr_prdata = '0;
      endcase
   end

   // front pipeline handshake
   logic [FRONT_STAGES-1:0] valid_ff;
   logic [FRONT_STAGES:0]   adv;
   logic                    div_in_stall;
   logic                    div_out_valid;
   logic                    div_out_stall;
   div_out_type             div_out;

   always_comb begin
      adv[FRONT_STAGES] = !div_in_stall;
      for (int k = FRONT_STAGES - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < FRONT_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // stage 1: centre and scale by pixel pitch
   logic signed [12:0] dc;
   logic signed [12:0] dr;
   logic signed [44:0] mx;
   logic signed [44:0] my;
   sat_type            sx_in;
   sat_type            sy_in;
   logic signed [31:0] s1_x_ff;
   logic signed [31:0] s1_y_ff;
   logic               s1_sat_ff;

   assign dc = $signed({1'b0, req_data.pixel_col}) - COL_HALF;
   assign dr = ROW_HALF - $signed({1'b0, req_data.pixel_row});
   assign mx = $signed({1'b0, pitch_col_ff}) * dc;
   assign my = $signed({1'b0, pitch_row_ff}) * dr;
   assign sx_in = sat32(66'(mx));
   assign sy_in = sat32(66'(my));

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_x_ff <= sx_in.value;
         s1_y_ff <= sy_in.value;
         s1_sat_ff <= sx_in.flag | sy_in.flag;
      end
   end

   // stage 2: depth scale products
   logic signed [63:0] px_in;
   logic signed [63:0] py_in;
   logic signed [63:0] pz_in;
   logic signed [63:0] s2_px_ff;
   logic signed [63:0] s2_py_ff;
   logic signed [63:0] s2_pz_ff;
   logic               s2_sat_ff;

   assign px_in = $signed({1'b0, depth_scale_ff}) * s1_x_ff;
   assign py_in = $signed({1'b0, depth_scale_ff}) * s1_y_ff;
   assign pz_in = $signed({1'b0, depth_scale_ff}) * $signed({1'b0, focal_length_ff});

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_px_ff <= px_in;
         s2_py_ff <= py_in;
         s2_pz_ff <= pz_in;
         s2_sat_ff <= s1_sat_ff;
      end
   end

   // stage 3: floor to q16.16 and clamp
   sat_type            x3_in;
   sat_type            y3_in;
   sat_type            z3_in;
   logic signed [31:0] s3_x3_ff;
   logic signed [31:0] s3_y3_ff;
   logic signed [31:0] s3_z3_ff;
   logic               s3_sat_ff;

   assign x3_in = sat32(66'(s2_px_ff >>> 16));
   assign y3_in = sat32(66'(s2_py_ff >>> 16));
   assign z3_in = sat32(66'(s2_pz_ff >>> 16));

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_x3_ff <= x3_in.value;
         s3_y3_ff <= y3_in.value;
         s3_z3_ff <= z3_in.value;
         s3_sat_ff <= s2_sat_ff | x3_in.flag | y3_in.flag | z3_in.flag;
      end
   end

   // stage 4: tilt rotation products
   logic signed [49:0] ys_in;
   logic signed [49:0] zc_in;
   logic signed [49:0] zs_in;
   logic signed [49:0] yc_in;
   logic signed [49:0] s4_ys_ff;
   logic signed [49:0] s4_zc_ff;
   logic signed [49:0] s4_zs_ff;
   logic signed [49:0] s4_yc_ff;
   logic signed [31:0] s4_x3_ff;
   logic               s4_sat_ff;

   assign ys_in = s3_y3_ff * sin_tilt_ff;
   assign zc_in = s3_z3_ff * cos_tilt_ff;
   assign zs_in = s3_z3_ff * sin_tilt_ff;
   assign yc_in = s3_y3_ff * cos_tilt_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_ys_ff <= ys_in;
         s4_zc_ff <= zc_in;
         s4_zs_ff <= zs_in;
         s4_yc_ff <= yc_in;
         s4_x3_ff <= s3_x3_ff;
         s4_sat_ff <= s3_sat_ff;
      end
   end

   // stage 5: rotated forward term and ground denominator
   logic signed [50:0] w_sum;
   logic signed [50:0] d_sum;
   sat_type            w3_in;
   logic signed [34:0] den_in;
   logic signed [31:0] s5_w3_ff;
   logic signed [34:0] s5_den_ff;
   logic signed [31:0] s5_x3_ff;
   logic               s5_sat_ff;

   assign w_sum = s4_ys_ff + s4_zc_ff;
   assign d_sum = s4_zs_ff - s4_yc_ff;
   assign w3_in = sat32(66'(w_sum >>> 16));
   assign den_in = 35'(d_sum >>> 16);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_w3_ff <= w3_in.value;
         s5_den_ff <= den_in;
         s5_x3_ff <= s4_x3_ff;
         s5_sat_ff <= s4_sat_ff | w3_in.flag;
      end
   end

   // stage 6: height-scaled numerators
   logic signed [63:0] nl_in;
   logic signed [63:0] nf_in;
   logic               miss_in;
   logic signed [63:0] s6_nl_ff;
   logic signed [63:0] s6_nf_ff;
   logic [DEN_W-1:0]   s6_den_ff;
   logic               s6_miss_ff;
   logic               s6_sat_ff;

   assign nl_in = $signed({1'b0, camera_height_ff}) * s5_x3_ff;
   assign nf_in = $signed({1'b0, camera_height_ff}) * s5_w3_ff;
   assign miss_in = s5_den_ff[34] || (s5_den_ff == '0);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_nl_ff <= nl_in;
         s6_nf_ff <= nf_in;
         s6_den_ff <= s5_den_ff[DEN_W-1:0];
         s6_miss_ff <= miss_in;
         s6_sat_ff <= s5_sat_ff;
      end
   end

   // stage 7: magnitudes and quotient range check
   logic [63:0] mag_lat;
   logic [63:0] mag_fwd;
   div_in_type  div_in;
   div_in_type  s7_div_ff;

   always_comb begin
      mag_lat = s6_nl_ff[63] ? 64'(-s6_nl_ff) : 64'(s6_nl_ff);
      mag_fwd = s6_nf_ff[63] ? 64'(-s6_nf_ff) : 64'(s6_nf_ff);
      div_in.num_lat = mag_lat[NUM_W-1:0];
      div_in.num_fwd = mag_fwd[NUM_W-1:0];
      div_in.ctl.den = s6_den_ff;
      div_in.ctl.sign_lat = s6_nl_ff[63];
      div_in.ctl.sign_fwd = s6_nf_ff[63];
      div_in.ctl.big_lat = DEN_W'(mag_lat[NUM_W-1:QUO_W]) >= s6_den_ff;
      div_in.ctl.big_fwd = DEN_W'(mag_fwd[NUM_W-1:QUO_W]) >= s6_den_ff;
      div_in.ctl.miss = s6_miss_ff;
      div_in.ctl.sat = s6_sat_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s7_div_ff <= div_in;
      end
   end

   // quotient pipeline
   pgp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[FRONT_STAGES-1]),
      .in_stall  (div_in_stall),
      .in_data   (s7_div_ff),
      .out_valid (div_out_valid),
      .out_stall (div_out_stall),
      .out_data  (div_out)
   );

   // final sign, clamp and status
   sat_type lat_res;
   sat_type fwd_res;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    rsp_load;

   assign lat_res = apply_sign(div_out.q_lat, div_out.ctl.sign_lat, div_out.ctl.big_lat);
   assign fwd_res = apply_sign(div_out.q_fwd, div_out.ctl.sign_fwd, div_out.ctl.big_fwd);

   always_comb begin
      if (div_out.ctl.miss) begin
         rsp_in = '{ground_lateral: '0, ground_forward: '0, status: STATUS_MISS};
      end else begin
         rsp_in.ground_lateral = lat_res.value;
         rsp_in.ground_forward = fwd_res.value;
         rsp_in.status = (div_out.ctl.sat | lat_res.flag | fwd_res.flag) ?
                         STATUS_SAT : STATUS_OK;
      end
   end

   // output register
   assign rsp_load = !rsp_valid_ff || !rsp_stall;
   assign div_out_stall = !rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `PGP_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid_ff && rsp_ff.status == STATUS_MISS, rsp_ff.ground_lateral == 0 && rsp_ff.ground_forward == 0, "missed ray with nonzero distance")
   `PGP_ASSERT_NOW(a_stall_full, clock, reset, req_stall, valid_ff[0], "input stalled while first stage is empty")
   `PGP_ASSERT_NEXT(a_div_to_out, clock, reset, div_out_valid && !div_out_stall, rsp_valid_ff, "quotient transfer lost before output")

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for pixel_to_ground_projection_unit
// depends on pgp_pkg for the transfer structs, register indexes and status codes
`timescale 1ns / 100ps

// tracks register settings and the queue of predicted ground points
class ground_scoreboard;
   longint pitch_row, pitch_col, focal_len, depth_scale, sin_tilt, cos_tilt, cam_height;
   pgp_pkg::rsp_type expected_points[$];
   int mismatches;

   function new();
      pitch_row = 0; pitch_col = 0; focal_len = 0; depth_scale = 65536;
      sin_tilt = 0; cos_tilt = 65536; cam_height = 0;
      mismatches = 0;
   endfunction

   // mirror of a register write; unknown indexes are dropped
   function void write_reg(int index, logic [31:0] value);
      case (index)
         pgp_pkg::REG_PITCH_ROW:     pitch_row   = longint'(value[30:0]);
         pgp_pkg::REG_PITCH_COL:     pitch_col   = longint'(value[30:0]);
         pgp_pkg::REG_FOCAL_LENGTH:  focal_len   = longint'(value[30:0]);
         pgp_pkg::REG_DEPTH_SCALE:   depth_scale = longint'(value[30:0]);
         pgp_pkg::REG_SIN_TILT:      sin_tilt    = longint'($signed(value[17:0]));
         pgp_pkg::REG_COS_TILT:      cos_tilt    = longint'($signed(value[17:0]));
         pgp_pkg::REG_CAMERA_HEIGHT: cam_height  = longint'(value[30:0]);
         default: ;
      endcase
   endfunction

   // clamp to signed 32 bit, noting any clamp
   function longint clamp32(longint v, inout bit clamped);
      if (v > 64'sd2147483647) begin
         clamped = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clamped = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // flat-ground intersection of the pixel ray, Q16.16 with floor shifts
   function pgp_pkg::rsp_type project_pixel(pgp_pkg::req_type px);
      pgp_pkg::rsp_type r;
      longint dc, dr, x, y, x3, y3, z3, w3, den;
      bit clamped;
      clamped = 0;
      dc = longint'(px.pixel_col) - pgp_pkg::IMAGE_COLS / 2;
      dr = pgp_pkg::IMAGE_ROWS / 2 - longint'(px.pixel_row);
      x  = clamp32(pitch_col * dc, clamped);
      y  = clamp32(pitch_row * dr, clamped);
      x3 = clamp32((depth_scale * x) >>> 16, clamped);
      y3 = clamp32((depth_scale * y) >>> 16, clamped);
      z3 = clamp32((depth_scale * focal_len) >>> 16, clamped);
      w3 = clamp32((y3 * sin_tilt + z3 * cos_tilt) >>> 16, clamped);
      den = (z3 * sin_tilt - y3 * cos_tilt) >>> 16;
      if (den <= 0) begin
         r.ground_lateral = '0;
         r.ground_forward = '0;
         r.status = pgp_pkg::STATUS_MISS;
      end else begin
         r.ground_lateral = 32'(clamp32((cam_height * x3) / den, clamped));
         r.ground_forward = 32'(clamp32((cam_height * w3) / den, clamped));
         r.status = clamped ? pgp_pkg::STATUS_SAT : pgp_pkg::STATUS_OK;
      end
      return r;
   endfunction

   function void note_pixel(pgp_pkg::req_type px);
      expected_points.push_back(project_pixel(px));
   endfunction

   function void check_point(pgp_pkg::rsp_type got);
      pgp_pkg::rsp_type want;
      if (expected_points.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result transfer: lat %0d fwd %0d status %0d",
                     got.ground_lateral, got.ground_forward, got.status);
         return;
      end
      want = expected_points.pop_front();
      if (got.ground_lateral !== want.ground_lateral ||
          got.ground_forward !== want.ground_forward || got.status !== want.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected lat %0d fwd %0d status %0d, got lat %0d fwd %0d status %0d",
                     want.ground_lateral, want.ground_forward, want.status,
                     got.ground_lateral, got.ground_forward, got.status);
      end
   endfunction
endclass

module testbench;
   import pgp_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int UNUSED_REG_INDEX = 7;
   localparam int DRAIN_CYCLES = 24;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_psel = 0;
   logic csr_penable = 0;
   logic csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   ground_scoreboard board = new();
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;

   pixel_to_ground_projection_unit dut (.*);

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stall pattern, switching between four random stall densities
   always @(posedge clock) begin
      if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // transfer monitors
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_pixel(req_data);
         if (rsp_valid && !rsp_stall) board.check_point(rsp_data);
      end
   end

   // one pixel transfer, with bursty gaps before it
   task automatic send_pixel(logic [11:0] row, logic [11:0] col);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data.pixel_row <= row;
      req_data.pixel_col <= col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // apb write: setup then access, then idle
   task automatic write_reg(int index, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(index * 4);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.write_reg(index, value);
      @(posedge clock);
   endtask

   // sender pauses until every predicted point has come back, then waits DRAIN_CYCLES more
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (board.expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random register value: zero, extreme, realistic or noise
   function automatic logic [31:0] pick_value(int index);
      int pick;
      pick = $urandom_range(0, 5);
      if (index == REG_SIN_TILT || index == REG_COS_TILT) begin
         case (pick)
            0: return 32'(-65536);
            1: return 32'd65536;
            2: return {$urandom} & 32'hFFFE0000 | 32'h1FFFF;
            3: return {$urandom} & 32'hFFFC0000 | 32'h20000;
            default: return $urandom;
         endcase
      end
      case (pick)
         0: return 32'd0;
         1: return 32'hFFFFFFFF;
         2: return $urandom_range(100, 700);
         3: return $urandom_range(65536, 600000);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_pixels(int count);
      repeat (count) begin
         if ($urandom_range(0, 7) == 0)
            send_pixel($urandom_range(0, 1) ? 12'hFFF : 12'h000,
                       $urandom_range(0, 1) ? 12'hFFF : 12'h000);
         else if ($urandom_range(0, 1) == 0)
            send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
         else
            send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
   endtask

   initial begin
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: every ray misses
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd512, 12'd512);
      send_pixel(12'hFFF, 12'hFFF);
      drain();

      // realistic downward-tilted camera
      write_reg(REG_PITCH_ROW, 32'd328);
      write_reg(REG_PITCH_COL, 32'd328);
      write_reg(REG_FOCAL_LENGTH, 32'd262144);
      write_reg(REG_DEPTH_SCALE, 32'd65536);
      write_reg(REG_SIN_TILT, 32'd32768);
      write_reg(REG_COS_TILT, 32'd56756);
      write_reg(REG_CAMERA_HEIGHT, 32'd98304);
      write_reg(UNUSED_REG_INDEX, 32'hFFFFFFFF);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd0, 12'd1023);
      send_pixel(12'd1023, 12'd0);
      send_pixel(12'd1023, 12'd1023);
      send_pixel(12'd512, 12'd512);
      send_pixel(12'd511, 12'd513);
      send_pixel(12'd700, 12'd300);
      send_pixel(12'd900, 12'd900);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);
      send_pixel(12'd1024, 12'd4000);
      random_pixels(60);
      drain();

      // all registers at their top, then at their bottom
      for (k = 0; k < 7; k++)
         write_reg(k, (k == REG_SIN_TILT || k == REG_COS_TILT) ? 32'h0001FFFF : 32'hFFFFFFFF);
      send_pixel(12'd0, 12'hFFF);
      send_pixel(12'hFFF, 12'd0);
      random_pixels(30);
      drain();
      for (k = 0; k < 7; k++)
         write_reg(k, (k == REG_SIN_TILT || k == REG_COS_TILT) ? 32'h00020000 : 32'h0);
      random_pixels(30);
      drain();

      // random settings
      repeat (8) begin
         for (k = 0; k < 7; k++)
            if ($urandom_range(0, 2) != 0) write_reg(k, pick_value(k));
         random_pixels(60);
         drain();
      end

      if (board.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
